### design/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

    localparam int WORD_BITS = 24;
    localparam int FRAC_BITS = 16;

    // Normalisation brings the largest magnitude into [2^NORM_LO, 2^NORM_HI)
    localparam int NORM_LO = 28;
    localparam int NORM_HI = 29;

    localparam int FW     = FRAC_BITS + 2;                  // unit axis component
    localparam int UW     = FRAC_BITS + 3;                  // true up component
    localparam int CW0    = WORD_BITS + FRAC_BITS + 3;      // raw cross product
    localparam int CW     = CW0;
    localparam int MW     = (CW0 > NORM_HI + 1) ? CW0 : NORM_HI + 1;
    localparam int MUL_W  = (WORD_BITS > NORM_HI + 1) ? WORD_BITS : NORM_HI + 1;
    localparam int PW     = 2 * MUL_W;
    localparam int ACC_W  = PW + 2;
    localparam int SQ_W   = 2 * NORM_HI + 3;
    localparam int LEN_W  = NORM_HI + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int NW     = NORM_HI + FRAC_BITS + 1;
    localparam int REM_W  = LEN_W;
    localparam int DC_W   = $clog2(QW);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WORD_BITS:0]   dvec_t;

    typedef struct packed {
        word_t [2:0] eye;
        word_t [2:0] up;
        dvec_t [2:0] dv;
    } job_t;

    typedef struct packed {
        logic [1:0] idx;
        word_t      r0;
        word_t      r1;
        word_t      r2;
        word_t      r3;
        logic       last;
        logic       degen;
    } col_t;

    localparam logic [1:0] LAST_COL = 2'd3;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [1:0] prv3(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : i - 2'd1;
    endfunction

    // Shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] half;
        logic [ACC_W-1:0] m;
        half = ACC_W'(1) << (FRAC_BITS - 1);
        mag  = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m    = (mag + half) >> FRAC_BITS;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            return v[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### design/lav_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire lav_pkg::word_t eye_x,
    input  wire lav_pkg::word_t eye_y,
    input  wire lav_pkg::word_t eye_z,
    input  wire lav_pkg::word_t target_x,
    input  wire lav_pkg::word_t target_y,
    input  wire lav_pkg::word_t target_z,
    input  wire lav_pkg::word_t upvec_x,
    input  wire lav_pkg::word_t upvec_y,
    input  wire lav_pkg::word_t upvec_z,
    output logic               head_valid,
    output lav_pkg::job_t      head,
    input  wire logic          head_pop
);
    import lav_pkg::*;

    job_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       job_in;
    logic       do_push;
    logic       do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rp_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    // Classify the word: keep eye and up, form the forward difference now
    always_comb
    begin
        job_in.eye[0] = eye_x;
        job_in.eye[1] = eye_y;
        job_in.eye[2] = eye_z;
        job_in.up[0]  = upvec_x;
        job_in.up[1]  = upvec_y;
        job_in.up[2]  = upvec_z;
        job_in.dv[0]  = (WORD_BITS+1)'(eye_x) - (WORD_BITS+1)'(target_x);
        job_in.dv[1]  = (WORD_BITS+1)'(eye_y) - (WORD_BITS+1)'(target_y);
        job_in.dv[2]  = (WORD_BITS+1)'(eye_z) - (WORD_BITS+1)'(target_z);
    end

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= job_in;
    end

endmodule

`default_nettype wire

### design/lav_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire lav_pkg::job_t head,
    output logic               head_pop,
    output logic               col_push,
    output lav_pkg::col_t      col_word,
    input  wire logic          col_full
);
    import lav_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_NSCAN  = 9'b000000010,
        S_NSHIFT = 9'b000000100,
        S_NSQ    = 9'b000001000,
        S_NSQRT  = 9'b000010000,
        S_NDSET  = 9'b000100000,
        S_NDIV   = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    typedef enum logic [4:0] {
        PH_F = 5'b00001,
        PH_C = 5'b00010,
        PH_S = 5'b00100,
        PH_U = 5'b01000,
        PH_T = 5'b10000
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    job_t                    job_reg, job_next;
    logic signed [CW-1:0]    vin_reg [3];
    logic signed [CW-1:0]    vin_next [3];
    logic [MW-1:0]           m_reg [3];
    logic [MW-1:0]           m_next [3];
    logic [2:0]              neg_reg, neg_next;
    logic signed [FW-1:0]    f_reg [3];
    logic signed [FW-1:0]    f_next [3];
    logic signed [FW-1:0]    s_reg [3];
    logic signed [FW-1:0]    s_next [3];
    logic signed [UW-1:0]    u_reg [3];
    logic signed [UW-1:0]    u_next [3];
    word_t                   t_reg [3];
    word_t                   t_next [3];
    logic                    deg_reg, deg_next;
    logic [1:0]              k_reg, k_next;
    logic [1:0]              tk_reg, tk_next;
    logic [1:0]              cmp_reg, cmp_next;
    logic                    mph_reg, mph_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SQ_W-1:0]         sqx_reg, sqx_next;
    logic [SQ_W-1:0]         sqr_reg, sqr_next;
    logic [SQ_W-1:0]         sqb_reg, sqb_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [QW-1:0]           nlo_reg, nlo_next;
    logic [QW-1:0]           q_reg, q_next;
    logic [DC_W-1:0]         dc_reg, dc_next;
    logic [1:0]              oc_reg, oc_next;

    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic [MW-1:0]           mx;
    logic [1:0]              ia;
    logic [1:0]              ib;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_n;
    logic [SQ_W-1:0]         sq_sum;
    logic [NW-1:0]           num;
    logic [REM_W:0]          trial;
    logic                    ge;
    logic signed [FW-1:0]    fval;
    logic                    norm_done;
    logic                    last_term;

    assign head_pop = (state_reg == S_IDLE) && head_valid;
    assign col_push = (state_reg == S_OUT) && !col_full;

    always_comb
    begin
        mx = (m_reg[0] > m_reg[1]) ? m_reg[0] : m_reg[1];
        if (m_reg[2] > mx)
            mx = m_reg[2];
        ia = tk_reg[0] ? prv3(cmp_reg) : nxt3(cmp_reg);
        ib = tk_reg[0] ? nxt3(cmp_reg) : prv3(cmp_reg);
    end

    // Operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NSQ:
            begin
                mul_a = $signed(MUL_W'(m_reg[k_reg][NORM_HI-1:0]));
                mul_b = $signed(MUL_W'(m_reg[k_reg][NORM_HI-1:0]));
            end
            S_MUL:
            begin
                case (phase_reg)
                    PH_C:
                    begin
                        mul_a = MUL_W'($signed(job_reg.up[ia]));
                        mul_b = MUL_W'(f_reg[ib]);
                    end
                    PH_U:
                    begin
                        mul_a = MUL_W'(f_reg[ia]);
                        mul_b = MUL_W'(s_reg[ib]);
                    end
                    PH_T:
                    begin
                        case (cmp_reg)
                            2'd0:    mul_a = MUL_W'(s_reg[tk_reg]);
                            2'd1:    mul_a = MUL_W'(u_reg[tk_reg]);
                            default: mul_a = MUL_W'(f_reg[tk_reg]);
                        endcase
                        mul_b = MUL_W'($signed(job_reg.eye[tk_reg]));
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        job_next   = job_reg;
        vin_next   = vin_reg;
        m_next     = m_reg;
        neg_next   = neg_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        u_next     = u_reg;
        t_next     = t_reg;
        deg_next   = deg_reg;
        k_next     = k_reg;
        tk_next    = tk_reg;
        cmp_next   = cmp_reg;
        mph_next   = mph_reg;
        acc_next   = acc_reg;
        sqx_next   = sqx_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        dc_next    = dc_reg;
        oc_next    = oc_reg;
        norm_done  = 1'b0;
        term       = '0;
        acc_n      = '0;
        sq_sum     = '0;
        num        = '0;
        trial      = '0;
        ge         = 1'b0;
        fval       = '0;
        last_term  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    job_next   = head;
                    for (int i = 0; i < 3; i++)
                        vin_next[i] = CW'($signed(head.dv[i]));
                    phase_next = PH_F;
                    deg_next   = 1'b0;
                    state_next = S_NSCAN;
                end
            end

            S_NSCAN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_next[i]   = MW'(vin_reg[i][CW-1] ? CW'(-vin_reg[i]) : CW'(vin_reg[i]));
                    neg_next[i] = vin_reg[i][CW-1];
                end
                state_next = S_NSHIFT;
            end

            S_NSHIFT:
            begin
                if (mx == '0)
                begin
                    // zero length: zero axis, flag the matrix
                    for (int i = 0; i < 3; i++)
                    begin
                        if (phase_reg == PH_F)
                            f_next[i] = '0;
                        else
                            s_next[i] = '0;
                    end
                    deg_next  = 1'b1;
                    norm_done = 1'b1;
                end
                else if (mx[MW-1:NORM_HI] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (mx[MW-1:NORM_LO] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    k_next     = 2'd0;
                    mph_next   = 1'b0;
                    state_next = S_NSQ;
                end
            end

            S_NSQ:
            begin
                if (!mph_reg)
                    mph_next = 1'b1;
                else
                begin
                    mph_next = 1'b0;
                    acc_n    = ((k_reg == 2'd0) ? '0 : acc_reg) + ACC_W'(prod_reg);
                    acc_next = acc_n;
                    if (k_reg == 2'd2)
                    begin
                        sqx_next   = acc_n[SQ_W-1:0];
                        sqr_next   = '0;
                        sqb_next   = SQ_W'(1) << (SQ_W - 1);
                        state_next = S_NSQRT;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end

            S_NSQRT:
            begin
                sq_sum = sqr_reg + sqb_reg;
                if (sqx_reg >= sq_sum)
                begin
                    sqx_next = sqx_reg - sq_sum;
                    sqr_next = (sqr_reg >> 1) + sqb_reg;
                end
                else
                    sqr_next = sqr_reg >> 1;
                sqb_next = sqb_reg >> 2;
                if (sqb_reg[0])
                begin
                    len_next   = sqr_next[LEN_W-1:0];
                    k_next     = 2'd0;
                    state_next = S_NDSET;
                end
            end

            S_NDSET:
            begin
                num        = (NW'(m_reg[k_reg][NORM_HI-1:0]) << FRAC_BITS)
                             + NW'(len_reg >> 1);
                rem_next   = REM_W'(num >> QW);
                nlo_next   = num[QW-1:0];
                q_next     = '0;
                dc_next    = DC_W'(QW - 1);
                state_next = S_NDIV;
            end

            S_NDIV:
            begin
                trial    = {rem_reg, nlo_reg[QW-1]};
                ge       = (trial >= {1'b0, len_reg});
                rem_next = ge ? REM_W'(trial - {1'b0, len_reg}) : REM_W'(trial);
                nlo_next = nlo_reg << 1;
                q_next   = {q_reg[QW-2:0], ge};
                if (dc_reg == '0)
                begin
                    fval = neg_reg[k_reg] ? -$signed(FW'(q_next)) : $signed(FW'(q_next));
                    if (phase_reg == PH_F)
                        f_next[k_reg] = fval;
                    else
                        s_next[k_reg] = fval;
                    if (k_reg == 2'd2)
                        norm_done = 1'b1;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_NDSET;
                    end
                end
                else
                    dc_next = dc_reg - DC_W'(1);
            end

            S_MUL:
            begin
                if (!mph_reg)
                    mph_next = 1'b1;
                else
                begin
                    mph_next  = 1'b0;
                    term      = (phase_reg != PH_T && tk_reg[0]) ? -ACC_W'(prod_reg)
                                                                : ACC_W'(prod_reg);
                    acc_n     = ((tk_reg == 2'd0) ? '0 : acc_reg) + term;
                    acc_next  = acc_n;
                    last_term = (phase_reg == PH_T) ? (tk_reg == 2'd2) : (tk_reg == 2'd1);
                    if (!last_term)
                        tk_next = tk_reg + 2'd1;
                    else
                    begin
                        tk_next = 2'd0;
                        case (phase_reg)
                            PH_C:    vin_next[cmp_reg] = acc_n[CW-1:0];
                            PH_U:    u_next[cmp_reg] = UW'(round_shift(acc_n));
                            PH_T:    t_next[cmp_reg] = sat_word(-round_shift(acc_n));
                            default: acc_next = acc_n;
                        endcase
                        if (cmp_reg != 2'd2)
                            cmp_next = cmp_reg + 2'd1;
                        else
                        begin
                            cmp_next = 2'd0;
                            case (phase_reg)
                                PH_C:
                                begin
                                    phase_next = PH_S;
                                    state_next = S_NSCAN;
                                end
                                PH_U:
                                    phase_next = PH_T;
                                default:
                                begin
                                    oc_next    = 2'd0;
                                    state_next = S_OUT;
                                end
                            endcase
                        end
                    end
                end
            end

            S_OUT:
            begin
                if (!col_full)
                begin
                    oc_next = oc_reg + 2'd1;
                    if (oc_reg == LAST_COL)
                        state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        if (norm_done)
        begin
            phase_next = (phase_reg == PH_F) ? PH_C : PH_U;
            tk_next    = 2'd0;
            cmp_next   = 2'd0;
            mph_next   = 1'b0;
            state_next = S_MUL;
        end
    end

    always_comb
    begin
        col_word.idx   = oc_reg;
        col_word.last  = (oc_reg == LAST_COL);
        col_word.degen = deg_reg;
        if (oc_reg == LAST_COL)
        begin
            col_word.r0 = t_reg[0];
            col_word.r1 = t_reg[1];
            col_word.r2 = t_reg[2];
            col_word.r3 = sat_word(ACC_W'(1) << FRAC_BITS);
        end
        else
        begin
            col_word.r0 = sat_word(ACC_W'(s_reg[oc_reg]));
            col_word.r1 = sat_word(ACC_W'(u_reg[oc_reg]));
            col_word.r2 = sat_word(ACC_W'(f_reg[oc_reg]));
            col_word.r3 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        job_reg   <= job_next;
        vin_reg   <= vin_next;
        m_reg     <= m_next;
        neg_reg   <= neg_next;
        f_reg     <= f_next;
        s_reg     <= s_next;
        u_reg     <= u_next;
        t_reg     <= t_next;
        deg_reg   <= deg_next;
        k_reg     <= k_next;
        tk_reg    <= tk_next;
        cmp_reg   <= cmp_next;
        mph_reg   <= mph_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sqx_reg   <= sqx_next;
        sqr_reg   <= sqr_next;
        sqb_reg   <= sqb_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        q_reg     <= q_next;
        dc_reg    <= dc_next;
        oc_reg    <= oc_next;
    end

endmodule

`default_nettype wire

### design/lav_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_outq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           col_push,
    input  wire lav_pkg::col_t  col_word,
    output logic                col_full,
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          column_index,
    output lav_pkg::word_t      entry_row0,
    output lav_pkg::word_t      entry_row1,
    output lav_pkg::word_t      entry_row2,
    output lav_pkg::word_t      entry_row3,
    output logic                last_column,
    output logic                degenerate
);
    import lav_pkg::*;

    col_t       q_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;
    col_t       hd;

    assign col_full = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign do_pop   = pop && !empty;
    assign hd       = q_reg[rp_reg];

    assign column_index = hd.idx;
    assign entry_row0   = hd.r0;
    assign entry_row1   = hd.r1;
    assign entry_row2   = hd.r2;
    assign entry_row3   = hd.r3;
    assign last_column  = hd.last;
    assign degenerate   = hd.degen;

    always_comb
    begin
        wp_next  = col_push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'd0, col_push} - {2'd0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_push)
            q_reg[wp_reg] <= col_word;
    end

endmodule

`default_nettype wire

### design/look_at_view_matrix_unit.sv
// Look-at view matrix unit.
// Input channel (push/full): one word holds eye, target and up vectors,
// signed Q7.16. A word is taken on a rising edge with push high and full low.
// Result channel (empty/pop): each input gives four column words in order
// 0..3, rows 0..2 = side, up, forward (column 3: the negated dot products
// with the eye), row 3 = 0 or 1.0, last_column on column 3, degenerate on all
// four if an axis had zero length. The head word shows while empty is low and
// leaves on an edge with pop high.
// A two-word input queue feeds a sequencer that runs everything through one
// shared multiplier, a one-bit-a-step square root and a one-bit-a-step
// divider. An item's time there is set by the serial square root and the
// serial divider of the two normalisations, and the normalising shifts vary
// with the input; an item whose forward axis has zero length skips both the
// square roots and the divisions. After the last multiply the column words go
// to the result queue. Inputs are taken while the back end works and a four-word result
// queue absorbs a stalled receiver; when it is full the back end holds, and
// once the input queue fills, full rises.
// Reset empties both queues and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lav_pkg::word_t eye_x,
    input  wire lav_pkg::word_t eye_y,
    input  wire lav_pkg::word_t eye_z,
    input  wire lav_pkg::word_t target_x,
    input  wire lav_pkg::word_t target_y,
    input  wire lav_pkg::word_t target_z,
    input  wire lav_pkg::word_t upvec_x,
    input  wire lav_pkg::word_t upvec_y,
    input  wire lav_pkg::word_t upvec_z,
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          column_index,
    output lav_pkg::word_t      entry_row0,
    output lav_pkg::word_t      entry_row1,
    output lav_pkg::word_t      entry_row2,
    output lav_pkg::word_t      entry_row3,
    output logic                last_column,
    output logic                degenerate
);
    import lav_pkg::*;

    logic  head_valid;
    job_t  head;
    logic  head_pop;
    logic  col_push;
    col_t  col_word;
    logic  col_full;

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .eye_x      (eye_x),
        .eye_y      (eye_y),
        .eye_z      (eye_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .upvec_x    (upvec_x),
        .upvec_y    (upvec_y),
        .upvec_z    (upvec_z),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    lav_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .col_push   (col_push),
        .col_word   (col_word),
        .col_full   (col_full)
    );

    lav_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .col_push     (col_push),
        .col_word     (col_word),
        .col_full     (col_full),
        .empty        (empty),
        .pop          (pop),
        .column_index (column_index),
        .entry_row0   (entry_row0),
        .entry_row1   (entry_row1),
        .entry_row2   (entry_row2),
        .entry_row3   (entry_row3),
        .last_column  (last_column),
        .degenerate   (degenerate)
    );

endmodule

`default_nettype wire

### design/lav_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire logic           pop,
    input  wire logic [1:0]     column_index,
    input  wire lav_pkg::word_t entry_row3,
    input  wire logic           last_column,
    input  wire logic           degenerate
);
    import lav_pkg::*;

    // last flag marks exactly the final column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_column == (column_index == LAST_COL)))
        else $error("last_column does not match column_index");

    a_row3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && column_index != LAST_COL) |-> (entry_row3 == '0))
        else $error("row 3 not zero on an axis column");

    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_column) ##1 !empty
            |-> (column_index == 2'($past(column_index, 1) + 2'd1)))
        else $error("column words out of order");

    a_degen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_column) ##1 !empty
            |-> (degenerate == $past(degenerate, 1)))
        else $error("degenerate flag changed within one matrix");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (.*);

`default_nettype wire
